// ----- rtl/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search unit.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int StackDepth = 16;
  localparam int WordW      = 32;
  localparam int CountW     = 5;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_SEARCH  = 2'd3
  } lss_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } lss_status_e;

  typedef struct packed {
    lss_op_e                  operation;
    logic signed [WordW-1:0]  value;
  } lss_in_t;

  typedef struct packed {
    lss_status_e              status;
    logic signed [WordW-1:0]  value_out;
    logic                     found;
    logic [CountW-1:0]        count;
    logic                     last;
  } lss_out_t;

  // controller to datapath
  typedef struct packed {
    logic        cap_en;
    logic        mem_we;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        walk_top;
    logic        walk_zero;
    logic        walk_inc;
    logic        walk_dec;
    logic        rd_en;
    logic        hit_clr;
    logic        hit_acc;
    logic        out_load;
    lss_status_e out_status;
    logic        out_use_rdata;
    logic        out_found;
    logic        out_last;
  } lss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_is_zero;
    logic walk_at_end;
    logic out_free;
  } lss_stat_t;

endpackage

// ----- rtl/lss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer for the stack: decodes each item, walks the entry memory for
// pop, display and search, and schedules every result.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lss_pkg::lss_op_e  in_op_i,
  output logic              in_ready_o,
  input  lss_pkg::lss_stat_t stat_i,
  output lss_pkg::lss_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_USE  = 2'd2;

  logic [1:0]       state_q, state_d;
  lss_pkg::lss_op_e op_q, op_d;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.out_status = lss_pkg::ST_OK;
    cmd_o.cap_en     = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = in_op_i;
          case (in_op_i)
            lss_pkg::OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = lss_pkg::ST_FULL;
              end else begin
                cmd_o.mem_we  = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            lss_pkg::OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = lss_pkg::ST_EMPTY;
              end else begin
                cmd_o.cnt_dec  = 1'b1;
                cmd_o.walk_top = 1'b1;
                state_d        = S_RD;
              end
            end
            lss_pkg::OP_DISPLAY: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = lss_pkg::ST_EMPTY;
              end else begin
                cmd_o.walk_top = 1'b1;
                state_d        = S_RD;
              end
            end
            lss_pkg::OP_SEARCH: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = lss_pkg::ST_EMPTY;
              end else begin
                cmd_o.walk_zero = 1'b1;
                cmd_o.hit_clr   = 1'b1;
                state_d         = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_USE;
      end
      S_USE: begin
        case (op_q)
          lss_pkg::OP_POP: begin
            if (stat_i.out_free) begin
              cmd_o.out_load      = 1'b1;
              cmd_o.out_use_rdata = 1'b1;
              cmd_o.out_last      = 1'b1;
              state_d             = S_IDLE;
            end
          end
          lss_pkg::OP_DISPLAY: begin
            // hold the entry until the output register frees up
            if (stat_i.out_free) begin
              cmd_o.out_load      = 1'b1;
              cmd_o.out_use_rdata = 1'b1;
              cmd_o.out_last      = stat_i.walk_is_zero;
              if (stat_i.walk_is_zero) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.walk_dec = 1'b1;
                state_d        = S_RD;
              end
            end
          end
          lss_pkg::OP_SEARCH: begin
            if (stat_i.walk_at_end) begin
              if (stat_i.out_free) begin
                cmd_o.out_load  = 1'b1;
                cmd_o.out_found = 1'b1;
                cmd_o.out_last  = 1'b1;
                state_d         = S_IDLE;
              end
            end else begin
              cmd_o.hit_acc  = 1'b1;
              cmd_o.walk_inc = 1'b1;
              state_d        = S_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= lss_pkg::OP_PUSH;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ----- rtl/lss_dpath.sv -----
// ----------------------------------------------------------------------------
// lss_dpath
// Entry memory, depth counter, walk cursor, search hit flag and the
// result register.
// ----------------------------------------------------------------------------
module lss_dpath #(
  parameter int STACK_DEPTH = lss_pkg::StackDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lss_pkg::lss_in_t   in_data_i,
  input  lss_pkg::lss_cmd_t  cmd_i,
  output lss_pkg::lss_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lss_pkg::lss_out_t  out_data_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [lss_pkg::WordW-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             walk_q, walk_d;
  logic [lss_pkg::WordW-1:0] value_q;
  logic [lss_pkg::WordW-1:0] rdata_q;
  logic                      hit_q, hit_d;
  logic                      match;
  logic                      out_valid_q, out_valid_d;
  lss_pkg::lss_out_t         out_q, out_d;
  logic [CW-1:0]             top;

  assign top   = count_q - CW'(1);
  assign match = (rdata_q == value_q);

  assign stat_o.empty        = (count_q == '0);
  assign stat_o.full         = (count_q == CW'(STACK_DEPTH));
  assign stat_o.walk_is_zero = (walk_q == '0);
  assign stat_o.walk_at_end  = (CW'(walk_q) == top);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = top;
    end
  end

  always_comb begin
    walk_d = walk_q;
    if (cmd_i.walk_top) begin
      walk_d = top[AW-1:0];
    end else if (cmd_i.walk_zero) begin
      walk_d = '0;
    end else if (cmd_i.walk_inc) begin
      walk_d = walk_q + AW'(1);
    end else if (cmd_i.walk_dec) begin
      walk_d = walk_q - AW'(1);
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (cmd_i.hit_clr) begin
      hit_d = 1'b0;
    end else if (cmd_i.hit_acc) begin
      hit_d = hit_q | match;
    end
  end

  always_comb begin
    out_d           = out_q;
    out_valid_d     = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d     = 1'b1;
      out_d.status    = cmd_i.out_status;
      out_d.value_out = cmd_i.out_use_rdata ? rdata_q : '0;
      out_d.found     = cmd_i.out_found && (hit_q || match);
      out_d.count     = lss_pkg::CountW'(count_d);
      out_d.last      = cmd_i.out_last;
    end
  end

  // entry store, single write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[count_q[AW-1:0]] <= in_data_i.value;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[walk_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      value_q <= in_data_i.value;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      walk_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      walk_q      <= walk_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("entry count above depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> stat_o.out_free)
    else $error("result loaded over an unread item");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_we |-> !stat_o.full)
    else $error("write into a full stack");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> !stat_o.empty)
    else $error("pop from an empty stack");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result changed under stall");
`endif

endmodule

// ----- rtl/lifo_stack_with_search_unit.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit
// LIFO stack of signed words with pop, push, top-down display and search.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (lss_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (lss_out_t)
//
//  Push, and pop, display or search on an empty stack: result in the cycle
//  after accept. Pop steps through the read and use states, display and
//  search through read and use once per held entry; no new item is taken
//  until the walk ends, paced by the single registered read port of the store.
//  Reset is asynchronous; the entry store has no clearing pass.
//  A stalled result holds in the output register; a new item is taken only
//  while idle and when that register is empty or being drained.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit #(
  parameter int STACK_DEPTH = lss_pkg::StackDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lss_pkg::lss_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lss_pkg::lss_out_t out_data_o
);

  lss_pkg::lss_cmd_t  cmd;
  lss_pkg::lss_stat_t stat;

  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lss_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- test/lifo_stack_with_search_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit_test
// Self-checking bench for the LIFO stack with search. A queue of requests
// feeds a valid/ready driver: first a directed run over the empty, full and
// extreme-word cases, then phases that alternately fill and drain the stack.
// A shadow stack predicts every result. The monitor compares each result
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit_test;

  localparam int NumRandom = 460;
  localparam int DrainCycles = 64;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  lss_pkg::lss_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  lss_pkg::lss_out_t out_data;

  lifo_stack_with_search_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // request queue and result expectations
  lss_pkg::lss_in_t  pending_reqs[$];
  lss_pkg::lss_out_t expected_results[$];

  // shadow stack, bottom at index 0
  logic signed [lss_pkg::WordW-1:0] shadow_words[lss_pkg::StackDepth];
  int shadow_fill = 0;

  int items_taken = 0;
  int items_posted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int refused_pushes = 0;
  int empty_requests = 0;
  int search_hits = 0;
  int display_rows = 0;

  int gap_left = 0;
  int stall_left = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t: result %0d: %s", $time, results_seen, msg);
  endtask

  function automatic lss_pkg::lss_out_t make_result(lss_pkg::lss_status_e st,
                                                    logic signed [lss_pkg::WordW-1:0] word,
                                                    logic hit, logic fin);
    lss_pkg::lss_out_t r;
    r.status = st;
    r.value_out = word;
    r.found = hit;
    r.count = lss_pkg::CountW'(shadow_fill);
    r.last = fin;
    return r;
  endfunction

  // advance the shadow stack by one request and queue what it should produce
  task automatic predict_stack_results(lss_pkg::lss_in_t req);
    logic hit;
    hit = 1'b0;
    case (req.operation)
      lss_pkg::OP_PUSH: begin
        if (shadow_fill >= lss_pkg::StackDepth) begin
          refused_pushes++;
          expected_results.push_back(make_result(lss_pkg::ST_FULL, '0, 1'b0, 1'b1));
        end else begin
          shadow_words[shadow_fill] = req.value;
          shadow_fill++;
          expected_results.push_back(make_result(lss_pkg::ST_OK, '0, 1'b0, 1'b1));
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          empty_requests++;
          expected_results.push_back(make_result(lss_pkg::ST_EMPTY, '0, 1'b0, 1'b1));
        end else if (req.operation == lss_pkg::OP_POP) begin
          shadow_fill--;
          expected_results.push_back(make_result(lss_pkg::ST_OK, shadow_words[shadow_fill],
                                                 1'b0, 1'b1));
        end else if (req.operation == lss_pkg::OP_DISPLAY) begin
          for (int i = shadow_fill; i > 0; i--) begin
            display_rows++;
            expected_results.push_back(make_result(lss_pkg::ST_OK, shadow_words[i-1], 1'b0,
                                                   i == 1));
          end
        end else begin
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_words[i] == req.value) hit = 1'b1;
          end
          if (hit) search_hits++;
          expected_results.push_back(make_result(lss_pkg::ST_OK, '0, hit, 1'b1));
        end
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_req(lss_pkg::lss_op_e op, logic signed [lss_pkg::WordW-1:0] word);
    lss_pkg::lss_in_t req;
    req.operation = op;
    req.value = word;
    pending_reqs.push_back(req);
  endtask

  function automatic logic signed [lss_pkg::WordW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return int'($urandom_range(0, 7)) - 4;
    if (r == 8) return 32'sh8000_0000;
    return 32'sh7fff_ffff;
  endfunction

  // input driver: hold the item until accepted, then idle or load the next
  always @(negedge clk_i) begin : drive_in
    logic             nxt_valid;
    lss_pkg::lss_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (rst_ni) begin
      if (in_valid && items_taken == items_posted) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt_data = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          items_posted++;
          // post the first 30 of every 100 items with no gap
          gap_left = (items_posted % 100 < 30) ? 0 : pick_gap();
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // output side: random back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (results_seen % 120 >= 35 && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : watch
    lss_pkg::lss_out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, value_out %0d",
                                    out_data.value_out));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status,
                                      out_data.status));
          if (out_data.value_out !== want.value_out)
            report_mismatch($sformatf("value_out expected %0d got %0d", want.value_out,
                                      out_data.value_out));
          if (out_data.found !== want.found)
            report_mismatch($sformatf("found expected %0d got %0d", want.found,
                                      out_data.found));
          if (out_data.count !== want.count)
            report_mismatch($sformatf("count expected %0d got %0d", want.count,
                                      out_data.count));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last expected %0d got %0d", want.last,
                                      out_data.last));
        end
        results_seen++;
      end
      // check before predicting: a result never leaves on the edge its item enters
      if (in_valid && in_ready) begin
        predict_stack_results(in_data);
        items_taken++;
      end
    end
  end

  initial begin
    int r;
    lss_pkg::lss_op_e op;

    // directed: empty stack, extreme words, fill to capacity, refused push
    queue_req(lss_pkg::OP_POP, 32'sd0);
    queue_req(lss_pkg::OP_DISPLAY, 32'sd0);
    queue_req(lss_pkg::OP_SEARCH, 32'sd0);
    queue_req(lss_pkg::OP_PUSH, 32'sh8000_0000);
    queue_req(lss_pkg::OP_PUSH, 32'sh7fff_ffff);
    queue_req(lss_pkg::OP_PUSH, 32'sd0);
    queue_req(lss_pkg::OP_PUSH, -32'sd1);
    queue_req(lss_pkg::OP_SEARCH, 32'sh7fff_ffff);
    queue_req(lss_pkg::OP_SEARCH, 32'sd5);
    for (int i = 0; i < lss_pkg::StackDepth - 4; i++) queue_req(lss_pkg::OP_PUSH, $urandom);
    queue_req(lss_pkg::OP_PUSH, 32'sh1234_5678);
    queue_req(lss_pkg::OP_DISPLAY, 32'sd0);
    queue_req(lss_pkg::OP_SEARCH, 32'sh8000_0000);
    queue_req(lss_pkg::OP_POP, 32'sd0);

    // random: alternate fill-heavy and drain-heavy phases of 40 items
    for (int k = 0; k < NumRandom; k++) begin
      r = $urandom_range(0, 99);
      if ((k / 40) % 2 == 0)
        op = (r < 60) ? lss_pkg::OP_PUSH : (r < 75) ? lss_pkg::OP_POP :
             (r < 85) ? lss_pkg::OP_DISPLAY : lss_pkg::OP_SEARCH;
      else
        op = (r < 20) ? lss_pkg::OP_PUSH : (r < 70) ? lss_pkg::OP_POP :
             (r < 80) ? lss_pkg::OP_DISPLAY : lss_pkg::OP_SEARCH;
      queue_req(op, pick_word());
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: %0d refused pushes, %0d empty requests,",
             items_taken, results_seen, refused_pushes, empty_requests);
    $display("%0d search hits and %0d displayed rows.", search_hits, display_rows);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** lifo_stack_with_search_unit: PASSED **");
    end else begin
      $display("** lifo_stack_with_search_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("** lifo_stack_with_search_unit: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lss_pkg.sv
rtl/lss_ctrl.sv
rtl/lss_dpath.sv
rtl/lifo_stack_with_search_unit.sv
test/lifo_stack_with_search_unit_test.sv
